[sv/stt_pkg.sv]
`default_nettype none

package stt_pkg;

    // Position counter width; positions saturate at all ones
    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Records the scanner can produce for one request
    localparam int MAX_RECS = 3;
    localparam int REC_CNT_W = $clog2(MAX_RECS + 1);

    // Token kinds
    localparam logic [4:0] KIND_LPAREN = 5'd0;
    localparam logic [4:0] KIND_RPAREN = 5'd1;
    localparam logic [4:0] KIND_PLUS   = 5'd2;
    localparam logic [4:0] KIND_MINUS  = 5'd3;
    localparam logic [4:0] KIND_STAR   = 5'd4;
    localparam logic [4:0] KIND_SLASH  = 5'd5;
    localparam logic [4:0] KIND_EQUALS = 5'd6;
    localparam logic [4:0] KIND_ARROW  = 5'd7;
    localparam logic [4:0] KIND_INT    = 5'd8;
    localparam logic [4:0] KIND_IDENT  = 5'd9;
    localparam logic [4:0] KIND_ELSE   = 5'd10;
    localparam logic [4:0] KIND_FALSE  = 5'd11;
    localparam logic [4:0] KIND_FN     = 5'd12;
    localparam logic [4:0] KIND_IF     = 5'd13;
    localparam logic [4:0] KIND_IN     = 5'd14;
    localparam logic [4:0] KIND_LET    = 5'd15;
    localparam logic [4:0] KIND_REC    = 5'd16;
    localparam logic [4:0] KIND_THEN   = 5'd17;
    localparam logic [4:0] KIND_TRUE   = 5'd18;
    localparam logic [4:0] KIND_EOF    = 5'd19;
    localparam logic [4:0] KIND_LINE   = 5'd20;
    localparam logic [4:0] KIND_ERROR  = 5'd21;

    // Input action codes
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Characters with special meaning
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // Identifier capture: last five bytes plus a count saturating at six
    localparam int CAP_W = 40;
    localparam int CAP_CNT_W = 3;
    localparam logic [CAP_CNT_W-1:0] CAP_CNT_MAX = 3'd6;

    // One token record
    typedef struct packed {
        logic [4:0]       kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
    } rec_t;

    // Records from one scanned request, lowest index first
    typedef struct packed {
        rec_t [MAX_RECS-1:0]  recs;
        logic [REC_CNT_W-1:0] count;
    } scan_out_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))
            || (c == CH_USCORE);
    endfunction

    function automatic logic is_ident_cont(input logic [7:0] c);
        return is_ident_start(c) || is_digit(c) || (c == CH_SQUOTE) || (c == CH_DQUOTE);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_PLUS)
            || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        k = KIND_LPAREN;
        if (c == CH_RPAREN)     k = KIND_RPAREN;
        else if (c == CH_PLUS)  k = KIND_PLUS;
        else if (c == CH_MINUS) k = KIND_MINUS;
        else if (c == CH_STAR)  k = KIND_STAR;
        else if (c == CH_SLASH) k = KIND_SLASH;
        return k;
    endfunction

    // Map a captured identifier to a keyword kind, or plain identifier
    function automatic logic [4:0] kw_kind(input logic [CAP_W-1:0] cap,
                                           input logic [CAP_CNT_W-1:0] cnt);
        logic [4:0] k;
        k = KIND_IDENT;
        if (cnt == 3'd4 && cap == 40'h00_656C_7365)      k = KIND_ELSE;
        else if (cnt == 3'd5 && cap == 40'h66_616C_7365) k = KIND_FALSE;
        else if (cnt == 3'd2 && cap == 40'h00_0000_666E) k = KIND_FN;
        else if (cnt == 3'd2 && cap == 40'h00_0000_6966) k = KIND_IF;
        else if (cnt == 3'd2 && cap == 40'h00_0000_696E) k = KIND_IN;
        else if (cnt == 3'd3 && cap == 40'h00_006C_6574) k = KIND_LET;
        else if (cnt == 3'd3 && cap == 40'h00_0072_6563) k = KIND_REC;
        else if (cnt == 3'd4 && cap == 40'h00_7468_656E) k = KIND_THEN;
        else if (cnt == 3'd4 && cap == 40'h00_7472_7565) k = KIND_TRUE;
        return k;
    endfunction

endpackage

`default_nettype wire

[sv/source_text_tokenizer.sv]
// A request is taken into the input register and scanned once the queue has room;
// its records are written into the record queue and presented on the master side from there.
// Throughput: one request per cycle while the 8-entry record queue has room for
// a burst of three records; records leave the queue at one per cycle while m_axis_tready is high.
// Reset: rst_n clears the scanner state, the position counter and the queue.
`default_nettype none

module source_text_tokenizer
    import stt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tuser,   // [0] action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] start_res, [31:16] length
    output logic [4:0]       m_axis_tuser,   // [4:0] kind
    output logic             m_axis_tlast    // last_of_run
);

    logic       in_vld_reg;
    logic       in_action_reg;
    logic [7:0] in_ch_reg;
    logic       adv;
    logic       has_room;
    scan_out_t  scan_res;
    rec_t       out_rec;

    // Scan the held request once the queue can take its burst
    assign adv           = in_vld_reg && has_room;
    assign s_axis_tready = !in_vld_reg || has_room;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_axis_tready)
            in_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= s_axis_tuser;
            in_ch_reg     <= s_axis_tdata;
        end
    end

    stt_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .action (in_action_reg),
        .ch     (in_ch_reg),
        .result (scan_res)
    );

    stt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (scan_res),
        .has_room  (has_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_rec.len, out_rec.start};
    assign m_axis_tuser = out_rec.kind;

endmodule

`default_nettype wire

[sv/stt_scan.sv]
`default_nettype none

module stt_scan
    import stt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic       action,
    input  wire logic [7:0] ch,
    output scan_out_t       result
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_EQ
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       tok_begin_reg, tok_begin_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [CAP_CNT_W-1:0]   cap_cnt_reg, cap_cnt_next;
    logic                   err_open_reg, err_open_next;
    logic [POS_W-1:0]       err_begin_reg, err_begin_next;

    logic                   close_has;
    rec_t                   close_rec;
    rec_t                   err_rec;
    logic                   is_err_ch;
    rec_t [MAX_RECS-1:0]    recs;
    logic [REC_CNT_W-1:0]   n;

    // Record that closes the open token at the current position
    always_comb
    begin
        close_has = 1'b1;
        close_rec = '{kind: KIND_INT, start: tok_begin_reg, len: pos_reg - tok_begin_reg};
        unique case (mode_reg)
            MODE_IDLE:  close_has = 1'b0;
            MODE_IDENT: close_rec.kind = kw_kind(cap_reg, cap_cnt_reg);
            MODE_INT:   close_rec.kind = KIND_INT;
            MODE_EQ:
            begin
                close_rec.kind = KIND_EQUALS;
                close_rec.len  = POS_W'(1);
            end
        endcase
    end

    assign err_rec = '{kind: KIND_ERROR, start: err_begin_reg, len: pos_reg - err_begin_reg};

    assign is_err_ch = !is_op(ch) && (ch != CH_EQ) && (ch != CH_SPACE) && (ch != CH_TAB)
                    && (ch != CH_CR) && (ch != CH_LF) && !is_digit(ch) && !is_ident_start(ch);

    // Scan one request: produce records and the next scanner state
    always_comb
    begin
        recs           = '0;
        n              = '0;
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        tok_begin_next = tok_begin_reg;
        cap_next       = cap_reg;
        cap_cnt_next   = cap_cnt_reg;
        err_open_next  = err_open_reg;
        err_begin_next = err_begin_reg;

        if (action == ACT_END)
        begin
            if (close_has)
            begin
                recs[n] = close_rec;
                n = n + 1'b1;
            end
            if (err_open_reg)
            begin
                recs[n] = err_rec;
                n = n + 1'b1;
            end
            recs[n] = '{kind: KIND_EOF, start: pos_reg, len: '0};
            n = n + 1'b1;
            // Start a fresh buffer
            mode_next      = MODE_IDLE;
            pos_next       = '0;
            tok_begin_next = '0;
            cap_next       = '0;
            cap_cnt_next   = '0;
            err_open_next  = 1'b0;
            err_begin_next = '0;
        end
        else
        begin
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 1'b1;

            priority if (mode_reg == MODE_EQ && ch == CH_GT)
            begin
                recs[n] = '{kind: KIND_ARROW, start: tok_begin_reg, len: POS_W'(2)};
                n = n + 1'b1;
                mode_next = MODE_IDLE;
            end
            else if (mode_reg == MODE_IDENT && is_ident_cont(ch))
            begin
                cap_next = {cap_reg[CAP_W-9:0], ch};
                if (cap_cnt_reg < CAP_CNT_MAX)
                    cap_cnt_next = cap_cnt_reg + 1'b1;
            end
            else if (mode_reg == MODE_INT && is_digit(ch))
            begin
                mode_next = MODE_INT;
            end
            else
            begin
                if (close_has)
                begin
                    recs[n] = close_rec;
                    n = n + 1'b1;
                end
                mode_next = MODE_IDLE;

                if (is_err_ch)
                begin
                    // Open or extend the error run
                    if (!err_open_reg)
                    begin
                        err_open_next  = 1'b1;
                        err_begin_next = pos_reg;
                    end
                end
                else
                begin
                    // Flush the error run before the new token
                    if (err_open_reg)
                    begin
                        recs[n] = err_rec;
                        n = n + 1'b1;
                        err_open_next = 1'b0;
                    end
                    priority if (is_op(ch))
                    begin
                        recs[n] = '{kind: op_kind(ch), start: pos_reg, len: POS_W'(1)};
                        n = n + 1'b1;
                    end
                    else if (ch == CH_EQ)
                    begin
                        mode_next      = MODE_EQ;
                        tok_begin_next = pos_reg;
                    end
                    else if (ch == CH_LF)
                    begin
                        recs[n] = '{kind: KIND_LINE, start: pos_reg, len: '0};
                        n = n + 1'b1;
                    end
                    else if (is_digit(ch))
                    begin
                        mode_next      = MODE_INT;
                        tok_begin_next = pos_reg;
                    end
                    else if (is_ident_start(ch))
                    begin
                        mode_next      = MODE_IDENT;
                        tok_begin_next = pos_reg;
                        cap_next       = {{(CAP_W-8){1'b0}}, ch};
                        cap_cnt_next   = CAP_CNT_W'(1);
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
        end
    end

    // Report no records unless a request is being scanned
    always_comb
    begin
        result.recs  = recs;
        result.count = adv ? n : '0;
    end

    // Hold scanner state, advance on each scanned request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            pos_reg       <= '0;
            tok_begin_reg <= '0;
            cap_reg       <= '0;
            cap_cnt_reg   <= '0;
            err_open_reg  <= 1'b0;
            err_begin_reg <= '0;
        end
        else if (adv)
        begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            tok_begin_reg <= tok_begin_next;
            cap_reg       <= cap_next;
            cap_cnt_reg   <= cap_cnt_next;
            err_open_reg  <= err_open_next;
            err_begin_reg <= err_begin_next;
        end
    end

endmodule

`default_nettype wire

[sv/stt_queue.sv]
`default_nettype none

module stt_queue
    import stt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire scan_out_t   wr,
    output logic             has_room,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rec_t             out_rec,
    output logic             out_last
);

    localparam int DEPTH = 8;
    localparam int PTR_W = $clog2(DEPTH);

    typedef struct packed {
        rec_t rec;
        logic last;
    } entry_t;

    entry_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       cnt_reg;
    logic                 pop;
    logic [REC_CNT_W-1:0] last_idx;

    // Room for a full burst from one request
    assign has_room  = cnt_reg <= (PTR_W+1)'(DEPTH - MAX_RECS);
    assign out_valid = cnt_reg != '0;
    assign out_rec   = mem_reg[rd_ptr_reg].rec;
    assign out_last  = mem_reg[rd_ptr_reg].last;
    assign pop       = out_valid && out_ready;
    assign last_idx  = wr.count - 1'b1;

    // Store the burst; mark the final record of the request
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECS; i++)
        begin
            if (REC_CNT_W'(i) < wr.count)
            begin
                mem_reg[wr_ptr_reg + PTR_W'(i)].rec  <= wr.recs[i];
                mem_reg[wr_ptr_reg + PTR_W'(i)].last <= (REC_CNT_W'(i) == last_idx);
            end
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(wr.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_W+1)'(wr.count) - (PTR_W+1)'(pop);
        end
    end

endmodule

`default_nettype wire
